// ===== rtl/htfl_pkg.sv =====
// ----------------------------------------------------------------------------
// htfl_pkg: shared definitions for the handle table
// Capacity, derived widths, action and status codes, and the types that
// pass between the sequencer and the slot store.
// ----------------------------------------------------------------------------
package htfl_pkg;

   localparam int CAPACITY = 256;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = IDX_W + 1;

   localparam logic [CNT_W-1:0] CAP_CNT = CAPACITY[CNT_W-1:0];

   localparam logic [2:0] ACT_CREATE  = 3'd0;
   localparam logic [2:0] ACT_FIND    = 3'd1;
   localparam logic [2:0] ACT_ACQUIRE = 3'd2;
   localparam logic [2:0] ACT_DESTROY = 3'd3;
   localparam logic [2:0] ACT_FORGET  = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_BAD     = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   typedef struct packed {
      logic [15:0] scene_handle;
      logic [15:0] scene_key;
      logic [31:0] entity_id;
   } slot_rec_type;

   typedef struct packed {
      logic             rec_we;
      logic [IDX_W-1:0] rec_waddr;
      slot_rec_type     rec_wdata;
      logic [IDX_W-1:0] rec_raddr;
      logic             live_we;
      logic             live_val;
      logic [IDX_W-1:0] live_widx;
      logic [IDX_W-1:0] live_raddr;
      logic             fs_we;
      logic [IDX_W-1:0] fs_waddr;
      logic [IDX_W-1:0] fs_wdata;
      logic [IDX_W-1:0] fs_raddr;
   } store_cmd_type;

endpackage

// ===== rtl/htfl_store.sv =====
// ----------------------------------------------------------------------------
// htfl_store: slot records, live flags and free stack
// Record memory and free-stack memory with registered reads, plus one live
// flag per slot in flip-flops that reset clears.
// ----------------------------------------------------------------------------
module htfl_store (
   input  logic                        clock,
   input  logic                        reset,
   input  htfl_pkg::store_cmd_type     cmd,
   output htfl_pkg::slot_rec_type      rec_rdata,
   output logic [htfl_pkg::IDX_W-1:0]  fs_rdata,
   output logic                        live_rd
);

   logic [htfl_pkg::CAPACITY-1:0] live_ff;
   htfl_pkg::slot_rec_type        rec_mem [htfl_pkg::CAPACITY];
   logic [htfl_pkg::IDX_W-1:0]    fs_mem  [htfl_pkg::CAPACITY];
   htfl_pkg::slot_rec_type        rec_rdata_ff;
   logic [htfl_pkg::IDX_W-1:0]    fs_rdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
      end else if (cmd.live_we) begin
         live_ff[cmd.live_widx] <= cmd.live_val;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rec_we) begin
         rec_mem[cmd.rec_waddr] <= cmd.rec_wdata;
      end
      rec_rdata_ff <= rec_mem[cmd.rec_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.fs_we) begin
         fs_mem[cmd.fs_waddr] <= cmd.fs_wdata;
      end
      fs_rdata_ff <= fs_mem[cmd.fs_raddr];
   end

   assign rec_rdata = rec_rdata_ff;
   assign fs_rdata  = fs_rdata_ff;
   assign live_rd   = live_ff[cmd.live_raddr];

endmodule

// ===== rtl/handle_table_with_free_list_top.sv =====
// Flow from accept to result: decode, then scan, claim, pop or read as the action needs, then
// done, which loads the output register. Find-or-create and forget-scene scan the used slots,
// one slot record compared per cycle.
// Throughput: one item at a time; the block is ready again once the result sits in the output
// register, so a stalled response also holds off the next item.
// Reset: synchronous, active high; clears live flags and both counts, ready right after reset.
// ----------------------------------------------------------------------------
// handle_table_with_free_list_top: slot table with a LIFO free list
// Hands out one-based handles for entity records, recycles retired slots
// through a free stack, and scans the table for find and forget actions.
// ----------------------------------------------------------------------------
module handle_table_with_free_list_top (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // handle[15:0], scene_handle[31:16], scene_key[47:32], entity_id[79:48]
   input  logic [79:0] req_tdata,
   // action[2:0], entity_valid[3]
   input  logic [3:0]  req_tuser,
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // handle_out[8:0], scene_handle_out[24:9], scene_key_out[40:25],
   // entity_id_out[72:41], zero[79:73]
   output logic [79:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]  rsp_tuser
);

   localparam int IW = htfl_pkg::IDX_W;
   localparam int CW = htfl_pkg::CNT_W;

   // Sequencer states.
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_CLAIM  = 3'd3;
   localparam logic [2:0] S_POP    = 3'd4;
   localparam logic [2:0] S_READ   = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0]  state_ff, state_in;

   // Captured request fields.
   logic [2:0]  act_ff, act_in;
   logic [15:0] handle_ff, handle_in;
   logic [15:0] sh_ff, sh_in;
   logic [15:0] sk_ff, sk_in;
   logic [31:0] ent_ff, ent_in;
   logic        evld_ff, evld_in;

   // Table bookkeeping.
   logic [CW-1:0] used_ff, used_in;
   logic [CW-1:0] free_ff, free_in;
   logic [CW-1:0] scan_ff, scan_in;

   // Staged result, waiting for the output register.
   logic [CW-1:0] res_handle_ff, res_handle_in;
   logic [1:0]    res_status_ff, res_status_in;
   logic [15:0]   res_sh_ff, res_sh_in;
   logic [15:0]   res_sk_ff, res_sk_in;
   logic [31:0]   res_ent_ff, res_ent_in;

   // Output register.
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic [CW-1:0] rsp_handle_ff, rsp_handle_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [15:0]   rsp_sh_ff, rsp_sh_in;
   logic [15:0]   rsp_sk_ff, rsp_sk_in;
   logic [31:0]   rsp_ent_ff, rsp_ent_in;

   htfl_pkg::store_cmd_type cmd;
   htfl_pkg::slot_rec_type  rec_rdata;
   logic [IW-1:0]           fs_rdata;
   logic                    live_rd;

   logic          req_fire;
   logic [15:0]   hminus;
   logic [IW-1:0] hidx;
   logic          hbad;
   logic [CW-1:0] scan_next;
   logic          scan_last;
   logic          find_hit;
   logic          forget_hit;
   logic [CW-1:0] new_handle;

   htfl_store u_store (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .rec_rdata (rec_rdata),
      .fs_rdata  (fs_rdata),
      .live_rd   (live_rd)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid & req_tready;

   // Handle lookup: zero or beyond the fresh-slot mark is rejected outright.
   assign hminus = handle_ff - 16'd1;
   assign hidx   = hminus[IW-1:0];
   assign hbad   = (handle_ff == 16'd0) || (handle_ff > {{(16-CW){1'b0}}, used_ff});

   // Scan compare of the record read back for slot scan_ff.
   assign scan_next  = scan_ff + 1'b1;
   assign scan_last  = (scan_next == used_ff);
   assign find_hit   = live_rd && (rec_rdata.scene_key == sk_ff) &&
                       (rec_rdata.entity_id == ent_ff);
   assign forget_hit = live_rd && (rec_rdata.scene_handle == sh_ff);

   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      handle_in     = handle_ff;
      sh_in         = sh_ff;
      sk_in         = sk_ff;
      ent_in        = ent_ff;
      evld_in       = evld_ff;
      used_in       = used_ff;
      free_in       = free_ff;
      scan_in       = scan_ff;
      res_handle_in = res_handle_ff;
      res_status_in = res_status_ff;
      res_sh_in     = res_sh_ff;
      res_sk_in     = res_sk_ff;
      res_ent_in    = res_ent_ff;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      rsp_handle_in = rsp_handle_ff;
      rsp_status_in = rsp_status_ff;
      rsp_sh_in     = rsp_sh_ff;
      rsp_sk_in     = rsp_sk_ff;
      rsp_ent_in    = rsp_ent_ff;
      new_handle    = '0;

      cmd            = '0;
      cmd.rec_raddr  = scan_next[IW-1:0];
      cmd.live_raddr = scan_ff[IW-1:0];
      cmd.fs_raddr   = free_ff[IW-1:0] - 1'b1;
      cmd.rec_wdata  = '{scene_handle: sh_ff, scene_key: sk_ff, entity_id: ent_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               act_in    = req_tuser[2:0];
               evld_in   = req_tuser[3];
               handle_in = req_tdata[15:0];
               sh_in     = req_tdata[31:16];
               sk_in     = req_tdata[47:32];
               ent_in    = req_tdata[79:48];
               state_in  = S_DECODE;
            end
         end

         S_DECODE: begin
            // Every result field without meaning for the action stays zero.
            res_handle_in = '0;
            res_status_in = htfl_pkg::ST_OK;
            res_sh_in     = '0;
            res_sk_in     = '0;
            res_ent_in    = '0;
            scan_in       = '0;
            cmd.rec_raddr = '0;
            priority if ((act_ff == htfl_pkg::ACT_CREATE) ||
                         (act_ff == htfl_pkg::ACT_FIND)) begin
               if (!evld_ff) begin
                  res_status_in = htfl_pkg::ST_INVALID;
                  state_in      = S_DONE;
               end else if ((act_ff == htfl_pkg::ACT_FIND) && (used_ff != '0)) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_CLAIM;
               end
            end else if ((act_ff == htfl_pkg::ACT_ACQUIRE) ||
                         (act_ff == htfl_pkg::ACT_DESTROY)) begin
               cmd.live_raddr = hidx;
               cmd.rec_raddr  = hidx;
               if (hbad || !live_rd) begin
                  res_status_in = htfl_pkg::ST_BAD;
                  state_in      = S_DONE;
               end else if (act_ff == htfl_pkg::ACT_ACQUIRE) begin
                  state_in = S_READ;
               end else begin
                  // Retire the slot and push it onto the free stack.
                  cmd.live_we   = 1'b1;
                  cmd.live_val  = 1'b0;
                  cmd.live_widx = hidx;
                  if (free_ff < htfl_pkg::CAP_CNT) begin
                     cmd.fs_we    = 1'b1;
                     cmd.fs_waddr = free_ff[IW-1:0];
                     cmd.fs_wdata = hidx;
                     free_in      = free_ff + 1'b1;
                  end
                  state_in = S_DONE;
               end
            end else if (act_ff == htfl_pkg::ACT_FORGET) begin
               state_in = (used_ff != '0) ? S_SCAN : S_DONE;
            end else begin
               state_in = S_DONE;
            end
         end

         S_SCAN: begin
            // The record for scan_ff is on the read port; the next one is
            // being fetched in the same cycle.
            if (act_ff == htfl_pkg::ACT_FIND) begin
               if (find_hit) begin
                  res_handle_in = scan_next;
                  state_in      = S_DONE;
               end else if (scan_last) begin
                  state_in = S_CLAIM;
               end else begin
                  scan_in = scan_next;
               end
            end else begin
               if (forget_hit) begin
                  cmd.live_we   = 1'b1;
                  cmd.live_val  = 1'b0;
                  cmd.live_widx = scan_ff[IW-1:0];
                  if (free_ff < htfl_pkg::CAP_CNT) begin
                     cmd.fs_we    = 1'b1;
                     cmd.fs_waddr = free_ff[IW-1:0];
                     cmd.fs_wdata = scan_ff[IW-1:0];
                     free_in      = free_ff + 1'b1;
                  end
               end
               if (scan_last) begin
                  state_in = S_DONE;
               end else begin
                  scan_in = scan_next;
               end
            end
         end

         S_CLAIM: begin
            priority if (free_ff != '0) begin
               // Top of the free stack is read this cycle, used next cycle.
               free_in  = free_ff - 1'b1;
               state_in = S_POP;
            end else if (used_ff < htfl_pkg::CAP_CNT) begin
               cmd.rec_we    = 1'b1;
               cmd.rec_waddr = used_ff[IW-1:0];
               cmd.live_we   = 1'b1;
               cmd.live_val  = 1'b1;
               cmd.live_widx = used_ff[IW-1:0];
               used_in       = used_ff + 1'b1;
               res_handle_in = used_ff + 1'b1;
               state_in      = S_DONE;
            end else begin
               res_status_in = htfl_pkg::ST_FULL;
               state_in      = S_DONE;
            end
         end

         S_POP: begin
            new_handle    = {1'b0, fs_rdata} + 1'b1;
            cmd.rec_we    = 1'b1;
            cmd.rec_waddr = fs_rdata;
            cmd.live_we   = 1'b1;
            cmd.live_val  = 1'b1;
            cmd.live_widx = fs_rdata;
            res_handle_in = new_handle;
            state_in      = S_DONE;
         end

         S_READ: begin
            res_sh_in  = rec_rdata.scene_handle;
            res_sk_in  = rec_rdata.scene_key;
            res_ent_in = rec_rdata.entity_id;
            state_in   = S_DONE;
         end

         S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_handle_in = res_handle_ff;
               rsp_status_in = res_status_ff;
               rsp_sh_in     = res_sh_ff;
               rsp_sk_in     = res_sk_ff;
               rsp_ent_in    = res_ent_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_ff       <= '0;
         free_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         free_ff       <= free_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      handle_ff     <= handle_in;
      sh_ff         <= sh_in;
      sk_ff         <= sk_in;
      ent_ff        <= ent_in;
      evld_ff       <= evld_in;
      scan_ff       <= scan_in;
      res_handle_ff <= res_handle_in;
      res_status_ff <= res_status_in;
      res_sh_ff     <= res_sh_in;
      res_sk_ff     <= res_sk_in;
      res_ent_ff    <= res_ent_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_status_ff <= rsp_status_in;
      rsp_sh_ff     <= rsp_sh_in;
      rsp_sk_ff     <= rsp_sk_in;
      rsp_ent_ff    <= rsp_ent_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'd0, rsp_ent_ff, rsp_sk_ff, rsp_sh_ff, rsp_handle_ff};
   assign rsp_tuser  = rsp_status_ff;

   // Only retired slots are pushed, so the free stack never outgrows the
   // fresh-slot mark.
   a_free_le_used: assert property (@(posedge clock) disable iff (reset)
      free_ff <= used_ff)
      else $error("free stack holds more slots than were ever handed out");

   // A scan never looks past the fresh-slot mark.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (scan_ff < used_ff))
      else $error("scan index beyond used slots");

   // A full status is only reported when no slot is left anywhere.
   a_full_real: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DONE) && (res_status_ff == htfl_pkg::ST_FULL)) |->
      ((used_ff == htfl_pkg::CAP_CNT) && (free_ff == '0)))
      else $error("table full reported with slots available");

endmodule
